### rtl/sdcfc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sensor duty cycle frame checker
// no dependencies; used by sdcfc_core and sensor_duty_cycle_frame_checker

package sdcfc_pkg;

    // power phase of the sensor
    typedef enum logic [1:0] {
        PH_OFF     = 2'd0,
        PH_WARMUP  = 2'd1,
        PH_MEASURE = 2'd2
    } t_phase;

    // frame status codes
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_GOOD     = 2'd1,
        ST_CKS_BAD  = 2'd2,
        ST_HDR_BAD  = 2'd3
    } t_status;

    // item kind codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_OFF_TIME    = 2'd0;
    localparam logic [1:0] REG_WARMUP_TIME = 2'd1;
    localparam logic [1:0] REG_ON_TIME     = 2'd2;

    // configuration reset values
    localparam logic [15:0] OFF_TIME_RST    = 16'd10000;
    localparam logic [15:0] WARMUP_TIME_RST = 16'd30000;
    localparam logic [15:0] ON_TIME_RST     = 16'd50000;

    // frame layout
    localparam logic [7:0] HDR0       = 8'h42;
    localparam logic [7:0] HDR1       = 8'h4D;
    localparam logic [4:0] POS_HDR0   = 5'd0;
    localparam logic [4:0] POS_HDR1   = 5'd1;
    localparam logic [4:0] POS_PM_HI  = 5'd12;
    localparam logic [4:0] POS_PM_LO  = 5'd13;
    localparam logic [4:0] POS_CKS_HI = 5'd30;
    localparam logic [4:0] POS_CKS_LO = 5'd31;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    // input transaction payload
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic        power_enable;
        logic [1:0]  phase;
        logic [1:0]  frame_status;
        logic [15:0] pm25;
    } t_out_item;

    // configuration register set
    typedef struct packed {
        logic [15:0] off_time_ms;
        logic [15:0] warmup_time_ms;
        logic [15:0] on_time_ms;
    } t_cfg;

endpackage

### rtl/sdcfc_core.sv
`timescale 1ns / 1ps
// phase timer and frame checker state with its single-pass update logic
// depends on sdcfc_pkg

module sdcfc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  sdcfc_pkg::t_in_item  i_item,
    input  sdcfc_pkg::t_cfg      i_cfg,
    output sdcfc_pkg::t_out_item o_result
);

    sdcfc_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [4:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic        r_hdr_good, n_hdr_good;
    logic [15:0] r_reading, n_reading;
    logic [7:0]  r_cks_hi, n_cks_hi;

    logic [15:0]          w_elapsed_inc;
    logic [15:0]          w_recv;
    sdcfc_pkg::t_status   w_status;
    logic [15:0]          w_pm;

    // saturating timer increment and received checksum
    assign w_elapsed_inc = (r_elapsed != sdcfc_pkg::TIMER_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign w_recv        = {r_cks_hi, i_item.rx_byte};

    // next state for one transaction
    always_comb begin
        n_phase    = r_phase;
        n_elapsed  = r_elapsed;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_hdr_good = r_hdr_good;
        n_reading  = r_reading;
        n_cks_hi   = r_cks_hi;
        w_status   = sdcfc_pkg::ST_NONE;
        w_pm       = 16'd0;
        if (i_item.func == sdcfc_pkg::FUNC_TICK) begin
            n_elapsed = w_elapsed_inc;
            case (r_phase)
                sdcfc_pkg::PH_OFF: begin
                    // power-on restarts framing
                    if (w_elapsed_inc >= i_cfg.off_time_ms) begin
                        n_phase    = sdcfc_pkg::PH_WARMUP;
                        n_elapsed  = 16'd0;
                        n_pos      = 5'd0;
                        n_sum      = 16'd0;
                        n_hdr_good = 1'b0;
                        n_reading  = 16'd0;
                        n_cks_hi   = 8'd0;
                    end
                end
                sdcfc_pkg::PH_WARMUP: begin
                    if (w_elapsed_inc >= i_cfg.warmup_time_ms) begin
                        n_phase = sdcfc_pkg::PH_MEASURE;
                    end
                end
                default: begin
                    if (w_elapsed_inc >= i_cfg.on_time_ms) begin
                        n_phase   = sdcfc_pkg::PH_OFF;
                        n_elapsed = 16'd0;
                    end
                end
            endcase
        end else if (r_phase == sdcfc_pkg::PH_MEASURE) begin
            // header tracking
            if (r_pos == sdcfc_pkg::POS_HDR0) begin
                n_hdr_good = (i_item.rx_byte == sdcfc_pkg::HDR0);
            end else if (r_pos == sdcfc_pkg::POS_HDR1) begin
                n_hdr_good = r_hdr_good && (i_item.rx_byte == sdcfc_pkg::HDR1);
            end
            // running sum over every byte ahead of the checksum
            if (r_pos < sdcfc_pkg::POS_CKS_HI) begin
                n_sum = r_sum + {8'd0, i_item.rx_byte};
            end
            // field capture and end of frame
            if (r_pos == sdcfc_pkg::POS_PM_HI) begin
                n_reading = {i_item.rx_byte, 8'd0};
            end else if (r_pos == sdcfc_pkg::POS_PM_LO) begin
                n_reading = {r_reading[15:8], i_item.rx_byte};
            end else if (r_pos == sdcfc_pkg::POS_CKS_HI) begin
                n_cks_hi = i_item.rx_byte;
            end else if (r_pos == sdcfc_pkg::POS_CKS_LO) begin
                if (!r_hdr_good) begin
                    w_status = sdcfc_pkg::ST_HDR_BAD;
                end else if (w_recv != r_sum) begin
                    w_status = sdcfc_pkg::ST_CKS_BAD;
                end else begin
                    w_status = sdcfc_pkg::ST_GOOD;
                    w_pm     = r_reading;
                end
                n_sum = 16'd0;
            end
            n_pos = r_pos + 5'd1;
        end
    end

    // result fields reflect the phase after the transaction
    always_comb begin
        o_result.power_enable = (n_phase != sdcfc_pkg::PH_OFF);
        o_result.phase        = n_phase;
        o_result.frame_status = w_status;
        o_result.pm25         = w_pm;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= sdcfc_pkg::PH_OFF;
            r_elapsed  <= 16'd0;
            r_pos      <= 5'd0;
            r_sum      <= 16'd0;
            r_hdr_good <= 1'b0;
            r_reading  <= 16'd0;
            r_cks_hi   <= 8'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_elapsed  <= n_elapsed;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_hdr_good <= n_hdr_good;
            r_reading  <= n_reading;
            r_cks_hi   <= n_cks_hi;
        end
    end

endmodule

### rtl/sensor_duty_cycle_frame_checker.sv
`timescale 1ns / 1ps
// top level: handshake stages, configuration registers and the checker core
// depends on sdcfc_pkg and sdcfc_core

// Each transaction is either a one-millisecond tick or a received sensor byte and
// yields exactly one result: power enable, current phase, frame status and PM2.5.
// Transactions flow through an input register, the update logic in sdcfc_core
// and a result register, so one transaction is taken every cycle while
// i_out_ready stays high. Each result is held in the result register until it is
// taken. While a result waits for i_out_ready the input register still takes one
// more transaction, then o_in_ready drops until the result is taken. Configuration
// writes apply on the clock edge where i_cfg_we is high and should be made while
// idle.

module sensor_duty_cycle_frame_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sdcfc_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sdcfc_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic                 r_in_valid;
    sdcfc_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    sdcfc_pkg::t_out_item r_out_data;
    sdcfc_pkg::t_cfg      r_cfg;

    logic                 w_out_free;
    logic                 w_adv;
    sdcfc_pkg::t_out_item w_result;

    // pipeline flow control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_time_ms    <= sdcfc_pkg::OFF_TIME_RST;
            r_cfg.warmup_time_ms <= sdcfc_pkg::WARMUP_TIME_RST;
            r_cfg.on_time_ms     <= sdcfc_pkg::ON_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sdcfc_pkg::REG_OFF_TIME:    r_cfg.off_time_ms    <= i_cfg_data;
                sdcfc_pkg::REG_WARMUP_TIME: r_cfg.warmup_time_ms <= i_cfg_data;
                sdcfc_pkg::REG_ON_TIME:     r_cfg.on_time_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // update logic and state
    sdcfc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in_data),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a frame verdict only comes out while measuring
    a_status_in_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_status != sdcfc_pkg::ST_NONE)
        |-> (o_out_data.phase == sdcfc_pkg::PH_MEASURE))
        else $error("frame status outside measure phase");

    // reading is only reported with a good frame
    a_pm_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_status != sdcfc_pkg::ST_GOOD)
        |-> (o_out_data.pm25 == 16'd0))
        else $error("pm25 nonzero without good frame");

    // power enable follows phase
    a_power_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.power_enable == (o_out_data.phase != sdcfc_pkg::PH_OFF)))
        else $error("power enable disagrees with phase");

    // a held input transaction moves on as soon as the result stage frees up
    a_input_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_out_free) |=> r_out_valid)
        else $error("input transaction not passed to result stage");

endmodule

### tb/sensor_duty_cycle_frame_checker_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for sensor_duty_cycle_frame_checker: scripted and random
// tick/byte traffic checked against an in-bench duty-cycle and frame-check predictor
// depends on sdcfc_pkg and the sensor_duty_cycle_frame_checker rtl

module sensor_duty_cycle_frame_checker_tb;

    localparam int          RUN_LIMIT_NS  = 2_000_000;
    localparam int          DRAIN_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          LONG_HOLD     = 200;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    // readings that can be read straight off the phase rules
    localparam sdcfc_pkg::t_out_item AT_OFF =
        {1'b0, sdcfc_pkg::PH_OFF, sdcfc_pkg::ST_NONE, 16'd0};
    localparam sdcfc_pkg::t_out_item AT_WARMUP =
        {1'b1, sdcfc_pkg::PH_WARMUP, sdcfc_pkg::ST_NONE, 16'd0};
    localparam sdcfc_pkg::t_out_item AT_MEASURE =
        {1'b1, sdcfc_pkg::PH_MEASURE, sdcfc_pkg::ST_NONE, 16'd0};

    // one scripted step: a register write or a transaction with its known reading
    typedef struct packed {
        logic                 is_reg;
        logic [1:0]           reg_index;
        logic [15:0]          reg_value;
        sdcfc_pkg::t_in_item  item;
        sdcfc_pkg::t_out_item want;
    } t_script_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    sdcfc_pkg::t_in_item  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    sdcfc_pkg::t_out_item out_data;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    // predictor state
    sdcfc_pkg::t_cfg      duty_cfg = {sdcfc_pkg::OFF_TIME_RST, sdcfc_pkg::WARMUP_TIME_RST,
                                      sdcfc_pkg::ON_TIME_RST};
    sdcfc_pkg::t_phase    model_phase = sdcfc_pkg::PH_OFF;
    logic [15:0]          model_elapsed = '0;
    logic [4:0]           frame_pos = '0;
    logic [15:0]          frame_sum = '0;
    logic                 frame_hdr_ok = 1'b0;
    logic [15:0]          frame_pm = '0;
    logic [7:0]           frame_cks_hi = '0;

    sdcfc_pkg::t_out_item pending_readings[$];
    sdcfc_pkg::t_out_item oldest_reading;
    t_script_row          script[$];
    int                   mismatches = 0;
    int                   live_items = 0;
    bit                   sender_calm = 1'b0;
    bit                   receiver_calm = 1'b0;
    bit                   hold_request = 1'b0;

    sensor_duty_cycle_frame_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // advance the predicted duty cycle and frame state by one transaction
    function automatic sdcfc_pkg::t_out_item sensor_step(input sdcfc_pkg::t_in_item it);
        sdcfc_pkg::t_out_item res;
        sdcfc_pkg::t_status   status;
        logic [15:0]          pm;
        logic [7:0]           b;
        status = sdcfc_pkg::ST_NONE;
        pm = '0;
        b = it.rx_byte;
        if (it.func == sdcfc_pkg::FUNC_TICK) begin
            if (model_elapsed != sdcfc_pkg::TIMER_MAX) model_elapsed = model_elapsed + 16'd1;
            case (model_phase)
                sdcfc_pkg::PH_OFF: begin
                    // power-on restarts framing
                    if (model_elapsed >= duty_cfg.off_time_ms) begin
                        model_phase = sdcfc_pkg::PH_WARMUP;
                        model_elapsed = '0;
                        frame_pos = '0;
                        frame_sum = '0;
                        frame_hdr_ok = 1'b0;
                        frame_pm = '0;
                        frame_cks_hi = '0;
                    end
                end
                sdcfc_pkg::PH_WARMUP: begin
                    if (model_elapsed >= duty_cfg.warmup_time_ms) begin
                        model_phase = sdcfc_pkg::PH_MEASURE;
                    end
                end
                default: begin
                    if (model_elapsed >= duty_cfg.on_time_ms) begin
                        model_phase = sdcfc_pkg::PH_OFF;
                        model_elapsed = '0;
                    end
                end
            endcase
        end else if (model_phase == sdcfc_pkg::PH_MEASURE) begin
            // header check on the first two bytes
            if (frame_pos == sdcfc_pkg::POS_HDR0) begin
                frame_hdr_ok = (b == sdcfc_pkg::HDR0);
            end else if (frame_pos == sdcfc_pkg::POS_HDR1) begin
                frame_hdr_ok = frame_hdr_ok && (b == sdcfc_pkg::HDR1);
            end
            if (frame_pos < sdcfc_pkg::POS_CKS_HI) frame_sum = frame_sum + {8'h00, b};
            if (frame_pos == sdcfc_pkg::POS_PM_HI) begin
                frame_pm = {b, 8'h00};
            end else if (frame_pos == sdcfc_pkg::POS_PM_LO) begin
                frame_pm[7:0] = b;
            end else if (frame_pos == sdcfc_pkg::POS_CKS_HI) begin
                frame_cks_hi = b;
            end else if (frame_pos == sdcfc_pkg::POS_CKS_LO) begin
                // bad header wins over bad checksum
                if (!frame_hdr_ok) status = sdcfc_pkg::ST_HDR_BAD;
                else if ({frame_cks_hi, b} != frame_sum) status = sdcfc_pkg::ST_CKS_BAD;
                else begin
                    status = sdcfc_pkg::ST_GOOD;
                    pm = frame_pm;
                end
                frame_sum = '0;
            end
            frame_pos = frame_pos + 5'd1;
        end
        res.power_enable = (model_phase != sdcfc_pkg::PH_OFF);
        res.phase = model_phase;
        res.frame_status = status;
        res.pm25 = pm;
        return res;
    endfunction

    function automatic t_script_row reg_row(input logic [1:0] idx, input logic [15:0] val);
        t_script_row row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic t_script_row item_row(input logic func, input logic [7:0] b,
                                             input sdcfc_pkg::t_out_item want);
        t_script_row row;
        row = '0;
        row.item.func = func;
        row.item.rx_byte = b;
        row.want = want;
        return row;
    endfunction

    // offer one transaction after a random gap; predict its reading on acceptance
    task automatic send_item(input sdcfc_pkg::t_in_item it, input logic typed,
                             input sdcfc_pkg::t_out_item want);
        int                   gap;
        sdcfc_pkg::t_out_item predicted;
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 49) == 0) sender_calm = !sender_calm;
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        live_items++;
        predicted = sensor_step(it);
        pending_readings.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every outstanding reading
    task automatic drain_pipeline;
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0) begin
            $display("%0t: %0d expected readings never arrived", $time,
                     pending_readings.size());
            mismatches += pending_readings.size();
            pending_readings.delete();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sdcfc_pkg::REG_OFF_TIME:    duty_cfg.off_time_ms = val;
            sdcfc_pkg::REG_WARMUP_TIME: duty_cfg.warmup_time_ms = val;
            sdcfc_pkg::REG_ON_TIME:     duty_cfg.on_time_ms = val;
            default: ;
        endcase
    endtask

    // one configuration followed by random ticks, frames and noise
    task automatic run_duty_phase(input logic [15:0] off_ms, input logic [15:0] warm_ms,
                                  input logic [15:0] on_ms, input int target,
                                  input bit with_hold);
        int                  kind;
        int                  n;
        int                  flavor;
        int                  tick_at;
        logic [7:0]          fr[32];
        logic [15:0]         sum;
        sdcfc_pkg::t_in_item it;
        drain_pipeline();
        write_reg(sdcfc_pkg::REG_OFF_TIME, off_ms);
        write_reg(sdcfc_pkg::REG_WARMUP_TIME, warm_ms);
        write_reg(sdcfc_pkg::REG_ON_TIME, on_ms);
        write_reg(REG_UNUSED, 16'($urandom));
        live_items = 0;
        if (with_hold) hold_request = 1'b1;
        while (live_items < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // burst of millisecond ticks
                n = $urandom_range(1, 6);
                repeat (n) begin
                    it.func = sdcfc_pkg::FUNC_TICK;
                    it.rx_byte = 8'($urandom);
                    send_item(it, 1'b0, '0);
                end
            end else if (kind < 85) begin
                // finish a partial frame so the next one lines up
                if (model_phase == sdcfc_pkg::PH_MEASURE && frame_pos != 0) begin
                    n = 32 - frame_pos;
                    repeat (n) begin
                        it.func = sdcfc_pkg::FUNC_BYTE;
                        it.rx_byte = 8'($urandom);
                        send_item(it, 1'b0, '0);
                    end
                end
                // well-formed frame, then maybe spoil checksum or header
                flavor = $urandom_range(0, 2);
                fr[0] = sdcfc_pkg::HDR0;
                fr[1] = sdcfc_pkg::HDR1;
                for (int j = 2; j < 30; j++) fr[j] = 8'($urandom);
                if (flavor == 2) begin
                    n = $urandom_range(0, 1);
                    fr[n] = fr[n] ^ 8'($urandom_range(1, 255));
                end
                sum = '0;
                for (int j = 0; j < 30; j++) sum = sum + {8'h00, fr[j]};
                if (flavor == 1) sum = sum ^ (16'd1 << $urandom_range(0, 15));
                fr[30] = sum[15:8];
                fr[31] = sum[7:0];
                tick_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : 32;
                for (int j = 0; j < 32; j++) begin
                    if (j == tick_at) begin
                        it.func = sdcfc_pkg::FUNC_TICK;
                        it.rx_byte = 8'($urandom);
                        send_item(it, 1'b0, '0);
                    end
                    it.func = sdcfc_pkg::FUNC_BYTE;
                    it.rx_byte = fr[j];
                    send_item(it, 1'b0, '0);
                end
            end else begin
                // stray bytes that break frame alignment
                n = $urandom_range(1, 5);
                repeat (n) begin
                    it.func = sdcfc_pkg::FUNC_BYTE;
                    it.rx_byte = 8'($urandom);
                    send_item(it, 1'b0, '0);
                end
            end
        end
    endtask

    // result sink with random stalls and one long hold-off
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            stall = receiver_calm ? 0 : $urandom_range(0, 11);
            if ($urandom_range(0, 49) == 0) receiver_calm = !receiver_calm;
            if (stall != 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each result transaction with the oldest expected reading
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading pe=%0d phase=%0d status=%0d pm25=%0d",
                         $time, out_data.power_enable, out_data.phase,
                         out_data.frame_status, out_data.pm25);
                mismatches++;
            end else begin
                oldest_reading = pending_readings.pop_front();
                if (oldest_reading.power_enable !== out_data.power_enable ||
                    oldest_reading.phase !== out_data.phase ||
                    oldest_reading.frame_status !== out_data.frame_status ||
                    oldest_reading.pm25 !== out_data.pm25) begin
                    $display("%0t: pe/phase/status/pm25 expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, oldest_reading.power_enable, oldest_reading.phase,
                             oldest_reading.frame_status, oldest_reading.pm25,
                             out_data.power_enable, out_data.phase,
                             out_data.frame_status, out_data.pm25);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // main sequence
    initial begin
        logic [15:0] rnd_off;
        logic [15:0] rnd_warm;
        logic [15:0] rnd_on;

        // reset config: everything stays off, bytes dropped
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_OFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, 8'h00, AT_OFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, 8'hFF, AT_OFF));
        // write to the unused index is ignored; zero off and warmup times
        script.push_back(reg_row(REG_UNUSED, 16'hFFFF));
        script.push_back(reg_row(sdcfc_pkg::REG_OFF_TIME, 16'd0));
        script.push_back(reg_row(sdcfc_pkg::REG_WARMUP_TIME, 16'd0));
        script.push_back(reg_row(sdcfc_pkg::REG_ON_TIME, 16'd3));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'hFF, AT_WARMUP));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_MEASURE));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, sdcfc_pkg::HDR0, AT_MEASURE));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, sdcfc_pkg::HDR1, AT_MEASURE));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_MEASURE));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_OFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, sdcfc_pkg::HDR0, AT_OFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_WARMUP));
        // on time below warmup: measuring lasts one tick
        script.push_back(reg_row(sdcfc_pkg::REG_WARMUP_TIME, 16'd4));
        script.push_back(reg_row(sdcfc_pkg::REG_ON_TIME, 16'd1));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_WARMUP));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_WARMUP));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_WARMUP));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_MEASURE));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_OFF));
        // maximum times
        script.push_back(reg_row(sdcfc_pkg::REG_OFF_TIME, 16'hFFFF));
        script.push_back(reg_row(sdcfc_pkg::REG_WARMUP_TIME, 16'hFFFF));
        script.push_back(reg_row(sdcfc_pkg::REG_ON_TIME, 16'hFFFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_TICK, 8'h00, AT_OFF));
        script.push_back(item_row(sdcfc_pkg::FUNC_BYTE, 8'h80, AT_OFF));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg) begin
                drain_pipeline();
                write_reg(script[i].reg_index, script[i].reg_value);
            end else begin
                send_item(script[i].item, 1'b1, script[i].want);
            end
        end

        // long measuring windows with a stalled receiver early on
        run_duty_phase(16'd1, 16'd2, 16'hFFFF, 400, 1'b1);
        // short power cycles that cut frames
        run_duty_phase(16'd3, 16'd5, 16'd300, 280, 1'b0);
        // all times zero
        run_duty_phase(16'd0, 16'd0, 16'd0, 150, 1'b0);
        // warmup that never ends in this phase
        run_duty_phase(16'd1, 16'hFFFF, 16'hFFFF, 60, 1'b0);
        // random small timing, on time sometimes below warmup
        rnd_off = 16'($urandom_range(0, 8));
        rnd_warm = 16'($urandom_range(0, 20));
        rnd_on = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, rnd_warm))
                                              : rnd_warm + 16'($urandom_range(1, 500));
        run_duty_phase(rnd_off, rnd_warm, rnd_on, 250, 1'b0);
        run_duty_phase(16'd1, 16'd1, 16'($urandom_range(200, 1000)), 100, 1'b0);

        drain_pipeline();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
